// ===== design/rpd_pkg.sv =====
// Shared types and constants of the RGB565 palette and delta stream decoder.
package rpd_pkg;

	localparam int PALETTE_ENTRIES = 255;
	localparam int MAX_PIXELS      = 67108864;

	localparam int PAL_AW     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int LOAD_BYTES = 2 * PALETTE_ENTRIES;
	localparam int LOAD_W     = $clog2(LOAD_BYTES + 1);
	localparam int COUNT_W    = 27;

	localparam logic [7:0]         ESCAPE_CODE = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [4:0]         RB_MASK     = 5'h1f;
	localparam logic [5:0]         G_MASK      = 6'h3f;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Configuration register indexes.
	localparam logic [1:0] REG_PALETTE_ENABLE  = 2'd0;
	localparam logic [1:0] REG_DELTA_ENABLE    = 2'd1;
	localparam logic [1:0] REG_EXPECTED_PIXELS = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_COUNT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_RAW    = 2'd2,
		OP_END    = 2'd3
	} op_kind_t;

	// One classified operation handed from the front end to the back end.
	typedef struct packed {
		op_kind_t          kind;
		logic [PAL_AW-1:0] addr;
		logic [15:0]       value;
		logic              last;
		logic              trunc;
	} op_t;

	typedef struct packed {
		logic               palette_enable;
		logic               delta_enable;
		logic [COUNT_W-1:0] expected_pixels;
	} cfg_t;

endpackage

// ===== design/rpd_ifs.sv =====
// Channel interfaces of the decoder: byte stream, pixel results and configuration writes.
interface rpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpd_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	logic        pixel_valid;
	logic        end_of_image;
	logic [1:0]  status;

	modport source(output valid, output pixel, output pixel_valid, output end_of_image,
		output status, input ready);
	modport sink(input valid, input pixel, input pixel_valid, input end_of_image,
		input status, output ready);
endinterface

interface rpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/rgb565_palette_delta_decoder_top.sv =====
// Top level of the RGB565 palette, escape and delta stream decoder.
// Usage:
// The stream channel takes one decompressed image byte per transaction, with last_byte
// marking the final byte of an image. The pixels channel returns one transaction for each
// decoded pixel, and one for the last byte, which carries end_of_image and the status
// (ok, truncated palette, escape or pair, pixel count mismatch). Bytes that only load the
// palette, start an escape or hold a low byte return nothing.
// The cfg channel writes palette_enable (index 0), delta_enable (index 1) and
// expected_pixels (index 2); it is always ready and should be used only while idle.
// Throughput is one byte per cycle while the operation queue is not full. A result passes
// through the operation queue, the registered palette memory read and the output register
// in that order. When the receiver stalls, the output register holds, the back end stops
// popping, and the four-entry queue fills before stream ready drops.
// Reset clears the stream state and sets the registers to palette mode, no delta and an
// expected count of one; the palette memory is not cleared and is loaded by each stream.
module rgb565_palette_delta_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	rpd_byte_if.sink     stream,
	rpd_pixel_if.source  pixels,
	rpd_cfg_if.sink      cfg
);
	import rpd_pkg::*;

	cfg_t cfg_q;
	op_t  push_op, pop_op;
	logic push, pop, full, empty;

	// Configuration writes are always taken; unknown indexes are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palette_enable  <= 1'b1;
			cfg_q.delta_enable    <= 1'b0;
			cfg_q.expected_pixels <= COUNT_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PALETTE_ENABLE:  cfg_q.palette_enable  <= cfg.data[0];
				REG_DELTA_ENABLE:    cfg_q.delta_enable    <= cfg.data[0];
				REG_EXPECTED_PIXELS: cfg_q.expected_pixels <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each byte against the current mode and palette load state.
	rpd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.stream         (stream),
		.palette_enable (cfg_q.palette_enable),
		.queue_full     (full),
		.push           (push),
		.op             (push_op)
	);

	rpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (full),
		.empty   (empty)
	);

	// The back end owns the palette memory, the delta history and the pixel count.
	rpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (empty),
		.op          (pop_op),
		.pop         (pop),
		.pixels      (pixels)
	);

endmodule

// ===== design/rpd_front.sv =====
// Front end: accepts stream bytes, tracks palette load and byte pairing, emits operations.
module rpd_front (
	input  logic               clk,
	input  logic               arst_n,
	rpd_byte_if.sink           stream,
	input  logic               palette_enable,
	input  logic               queue_full,
	output logic               push,
	output rpd_pkg::op_t       op
);
	import rpd_pkg::*;

	logic [LOAD_W-1:0] load_q, load_n;
	logic [1:0]        pend_q, pend_n;
	logic [7:0]        low_q, low_n;
	logic              emit;
	logic              accept;
	logic [7:0]        b;

	assign b            = stream.data_byte;
	assign stream.ready = !queue_full;
	assign accept       = stream.valid && stream.ready;
	assign push         = accept && (emit || stream.last_byte);

	always_comb begin
		load_n   = load_q;
		pend_n   = pend_q;
		low_n    = low_q;
		emit     = 1'b0;
		op.kind  = OP_END;
		op.addr  = '0;
		op.value = '0;
		if (pend_q == 2'd1) begin
			op.kind  = OP_RAW;
			op.value = {b, low_q};
			pend_n   = 2'd0;
			emit     = 1'b1;
		end else if (pend_q >= 2'd2) begin
			low_n  = b;
			pend_n = 2'd1;
		end else if (palette_enable) begin
			if (load_q < LOAD_W'(LOAD_BYTES)) begin
				if (!load_q[0]) begin
					low_n = b;
				end else begin
					op.kind  = OP_WRITE;
					op.addr  = PAL_AW'(load_q >> 1);
					op.value = {b, low_q};
					emit     = 1'b1;
				end
				load_n = load_q + 1'b1;
			end else if (b == ESCAPE_CODE) begin
				pend_n = 2'd2;
			end else if (int'(b) < PALETTE_ENTRIES) begin
				op.kind = OP_LOOKUP;
				op.addr = PAL_AW'(b);
				emit    = 1'b1;
			end else begin
				// A code past the palette yields a zero pixel.
				op.kind = OP_RAW;
				emit    = 1'b1;
			end
		end else begin
			low_n  = b;
			pend_n = 2'd1;
		end
		op.last  = stream.last_byte;
		op.trunc = (pend_n != 2'd0) || (palette_enable && (load_n < LOAD_W'(LOAD_BYTES)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			pend_q <= '0;
			low_q  <= '0;
		end else if (accept) begin
			if (stream.last_byte) begin
				load_q <= '0;
				pend_q <= '0;
				low_q  <= '0;
			end else begin
				load_q <= load_n;
				pend_q <= pend_n;
				low_q  <= low_n;
			end
		end
	end

endmodule

// ===== design/rpd_queue.sv =====
// Short operation queue that decouples the front end from the back end.
module rpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpd_pkg::op_t  push_op,
	input  logic          pop,
	output rpd_pkg::op_t  pop_op,
	output logic          full,
	output logic          empty
);
	import rpd_pkg::*;

	op_t                 slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full   = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_op = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

// ===== design/rpd_back.sv =====
// Back end: palette memory, delta reconstruction, pixel count and end-of-stream status.
module rpd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rpd_pkg::cfg_t cfg,
	input  logic          queue_empty,
	input  rpd_pkg::op_t  op,
	output logic          pop,
	rpd_pixel_if.source   pixels
);
	import rpd_pkg::*;

	function automatic logic [15:0] add_565(input logic [15:0] a, input logic [15:0] c);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] bl;
		r  = (a[15:11] + c[15:11]) & RB_MASK;
		g  = (a[10:5] + c[10:5]) & G_MASK;
		bl = (a[4:0] + c[4:0]) & RB_MASK;
		return {r, g, bl};
	endfunction

	logic [15:0] pal_mem [PALETTE_ENTRIES];

	logic               v_s1;
	op_kind_t           kind_s1;
	logic [15:0]        value_s1;
	logic [15:0]        rdata_s1;
	logic               last_s1;
	logic               trunc_s1;

	logic               v_s2;
	logic [15:0]        pixel_s2;
	logic               pv_s2;
	logic               eoi_s2;
	status_t            status_s2;

	logic [15:0]        prev_q;
	logic               have_prev_q;
	logic [COUNT_W-1:0] cnt_q;

	logic               adv1, adv2, leave1, got;
	logic [15:0]        px_raw, px;
	logic [COUNT_W-1:0] cnt_n;
	status_t            status_n;

	assign adv2 = !v_s2 || pixels.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = !queue_empty && adv1;
	assign leave1 = v_s1 && adv2;

	always_comb begin
		got    = (kind_s1 == OP_LOOKUP) || (kind_s1 == OP_RAW);
		px_raw = (kind_s1 == OP_LOOKUP) ? rdata_s1 : value_s1;
		px     = (cfg.delta_enable && have_prev_q) ? add_565(px_raw, prev_q) : px_raw;
		cnt_n  = cnt_q;
		if (got && (cnt_q != COUNT_MAX)) begin
			cnt_n = cnt_q + 1'b1;
		end
		if (trunc_s1) begin
			status_n = ST_TRUNC;
		end else if (cnt_n != cfg.expected_pixels) begin
			status_n = ST_COUNT;
		end else begin
			status_n = ST_OK;
		end
	end

	// Palette memory: at most one write and one registered read per cycle, only on a pop.
	always_ff @(posedge clk) begin
		if (pop && (op.kind == OP_WRITE)) begin
			pal_mem[op.addr] <= op.value;
		end
		if (pop) begin
			rdata_s1 <= pal_mem[op.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1  <= op.kind;
			value_s1 <= op.value;
			last_s1  <= op.last;
			trunc_s1 <= op.trunc;
		end
		if (leave1) begin
			pixel_s2  <= got ? px : 16'h0000;
			pv_s2     <= got;
			eoi_s2    <= last_s1;
			status_s2 <= last_s1 ? status_n : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (adv1) begin
				v_s1 <= pop;
			end
			if (adv2) begin
				v_s2 <= v_s1 && (got || last_s1);
			end
			if (leave1) begin
				if (last_s1) begin
					prev_q      <= '0;
					have_prev_q <= 1'b0;
					cnt_q       <= '0;
				end else if (got) begin
					prev_q      <= px;
					have_prev_q <= 1'b1;
					cnt_q       <= cnt_n;
				end
			end
		end
	end

	assign pixels.valid        = v_s2;
	assign pixels.pixel        = pixel_s2;
	assign pixels.pixel_valid  = pv_s2;
	assign pixels.end_of_image = eoi_s2;
	assign pixels.status       = status_s2;

`ifndef SYNTHESIS
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !pv_s2 |-> eoi_s2)
		else $error("result with neither pixel nor end of image");
	a_empty_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !pv_s2 |-> pixel_s2 == 16'h0000)
		else $error("result without pixel carries nonzero pixel");
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !eoi_s2 |-> status_s2 == ST_OK)
		else $error("status set on a result that does not end the stream");
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		leave1 && last_s1 |=> cnt_q == '0 && !have_prev_q)
		else $error("stream state not cleared after last byte");
`endif

endmodule

// ===== test/rpd_pixel_checker.sv =====
// Checker for the RGB565 palette and delta decoder: predicts each pixel transaction and compares.
`timescale 1ns / 100ps
module rpd_pixel_checker (
	input  logic clk,
	input  logic arst_n,
	rpd_byte_if  stream,
	rpd_pixel_if pixels,
	rpd_cfg_if   cfg,
	output int   mismatches,
	output int   waiting
);
	import rpd_pkg::*;

	typedef struct packed {
		logic [15:0] pixel;
		logic        pixel_valid;
		logic        end_of_image;
		status_t     status;
	} pixel_result_t;

	pixel_result_t due_results[$];

	// Shadow of the decoder state and its registers.
	logic [15:0]        pal_mem [PALETTE_ENTRIES];
	logic [LOAD_W-1:0]  load_cnt;
	logic [1:0]         pend;
	logic [7:0]         lo_hold;
	logic [15:0]        prev_px;
	logic               have_prev;
	logic [COUNT_W-1:0] px_count;
	logic               pal_en;
	logic               delta_en;
	logic [COUNT_W-1:0] want_count;
	int                 reported;

	function automatic logic [15:0] sum_rgb565(logic [15:0] a, logic [15:0] p);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] bl;
		r  = a[15:11] + p[15:11];
		g  = a[10:5] + p[10:5];
		bl = a[4:0] + p[4:0];
		return {r, g, bl};
	endfunction

	task automatic restart_stream();
		load_cnt  = '0;
		pend      = '0;
		lo_hold   = '0;
		prev_px   = '0;
		have_prev = 1'b0;
		px_count  = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		pixel_result_t r;
		logic          got;
		logic [15:0]   word;
		got  = 1'b0;
		word = '0;
		if (pend == 2'd1) begin
			word = {b, lo_hold};
			pend = 2'd0;
			got  = 1'b1;
		end else if (pend >= 2'd2) begin
			lo_hold = b;
			pend    = 2'd1;
		end else if (pal_en) begin
			if (load_cnt < LOAD_BYTES) begin
				if (!load_cnt[0])
					lo_hold = b;
				else
					pal_mem[load_cnt[LOAD_W-1:1]] = {b, lo_hold};
				load_cnt = load_cnt + 1'b1;
			end else if (b == ESCAPE_CODE) begin
				pend = 2'd2;
			end else begin
				word = (b < PALETTE_ENTRIES) ? pal_mem[b] : 16'h0000;
				got  = 1'b1;
			end
		end else begin
			lo_hold = b;
			pend    = 2'd1;
		end

		if (got) begin
			if (delta_en && have_prev)
				word = sum_rgb565(word, prev_px);
			prev_px   = word;
			have_prev = 1'b1;
			if (px_count != COUNT_MAX)
				px_count = px_count + 1'b1;
		end

		if (got || last) begin
			r.pixel        = got ? word : 16'h0000;
			r.pixel_valid  = got;
			r.end_of_image = last;
			r.status       = ST_OK;
			if (last) begin
				if (pend != 2'd0 || (pal_en && load_cnt < LOAD_BYTES))
					r.status = ST_TRUNC;
				else if (px_count != want_count)
					r.status = ST_COUNT;
			end
			due_results.push_back(r);
		end

		if (last)
			restart_stream();
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t e;
		if (!arst_n) begin
			restart_stream();
			pal_en     = 1'b1;
			delta_en   = 1'b0;
			want_count = COUNT_W'(1);
			due_results.delete();
			mismatches = 0;
			reported   = 0;
			waiting    = 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.index)
					REG_PALETTE_ENABLE:  pal_en     = cfg.data[0];
					REG_DELTA_ENABLE:    delta_en   = cfg.data[0];
					REG_EXPECTED_PIXELS: want_count = cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end

			if (pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected pixel transaction: pixel %h valid %b end %b status %0d",
							$realtime, pixels.pixel, pixels.pixel_valid, pixels.end_of_image,
							pixels.status);
					end
				end else begin
					e = due_results.pop_front();
					if (pixels.pixel !== e.pixel || pixels.pixel_valid !== e.pixel_valid ||
						pixels.end_of_image !== e.end_of_image || pixels.status !== e.status) begin
						mismatches++;
						if (reported < 10) begin
							reported++;
							$display("%0t: mismatch, expected pixel %h valid %b end %b status %0d",
								$realtime, e.pixel, e.pixel_valid, e.end_of_image, e.status);
							$display("%0t:             got pixel %h valid %b end %b status %0d",
								$realtime, pixels.pixel, pixels.pixel_valid, pixels.end_of_image,
								pixels.status);
						end
					end
				end
			end

			if (stream.valid === 1'b1 && stream.ready === 1'b1)
				decode_byte(stream.data_byte, stream.last_byte);

			waiting = due_results.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the RGB565 palette and delta decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;
	import rpd_pkg::*;

	// The run is cut off here; a correct run needs a small fraction of it.
	localparam int LIMIT  = 1000000;
	// Cycles allowed after the last expected transaction for a byte that gives no result
	// to work its way through the queue, the palette read and the output register.
	localparam int SETTLE = 8;
	// Stream bytes after which the random part stops. One full palette load alone takes 510 of them.
	localparam int ITEMS    = 700;
	// Random codes and escapes in the directed palette stream.
	localparam int RUN_SYMS = 20;

	logic clk = 1'b0;
	logic arst_n;

	rpd_byte_if  stream_ch();
	rpd_pixel_if pixel_ch();
	rpd_cfg_if   cfg_ch();

	int mismatches;
	int waiting;
	int cycles = 0;

	// Flow control knobs: chance in percent that a burst of idling starts, and a flag that
	// turns all idling off for the closing part of the run.
	int gap_pct    = 0;
	bit calm       = 1'b0;
	int stall_left = 0;

	// Count of stream bytes accepted so far, palette loads included; it decides when the
	// random part stops.
	int content = 0;

	rgb565_palette_delta_decoder_top uut (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.pixels(pixel_ch),
		.cfg   (cfg_ch)
	);

	rpd_pixel_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_ch),
		.pixels    (pixel_ch),
		.cfg       (cfg_ch),
		.mismatches(mismatches),
		.waiting   (waiting)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver side stalls in bursts. Exactly one assignment to ready is made per
	// falling edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			pixel_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(99) < gap_pct) begin
			stall_left = $urandom_range(1, 14) - 1;
			pixel_ch.ready <= 1'b0;
		end else begin
			pixel_ch.ready <= 1'b1;
		end
	end

	// Offers one byte and returns at the edge where the transaction completes. Valid is left
	// high so that the next byte can follow back to back; the next call either changes the
	// payload or drops valid for an idle burst, never both in the same step.
	task automatic put_byte(input logic [7:0] b, input logic last);
		int n;
		if (!calm && $urandom_range(99) < gap_pct) begin
			n = $urandom_range(1, 14);
			@(negedge clk) stream_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		stream_ch.valid     <= 1'b1;
		stream_ch.data_byte <= b;
		stream_ch.last_byte <= last;
		@(posedge clk);
		while (stream_ch.ready !== 1'b1) @(posedge clk);
		content++;
	endtask

	// Brings the block to rest: no byte offered, every predicted transaction received, and
	// enough cycles passed for a byte without a result to leave the pipeline.
	task automatic quiesce();
		@(negedge clk) stream_ch.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	// Writes all three registers. The unused upper data bits carry random values, which the
	// block has to ignore.
	task automatic set_mode(input bit pal, input bit dlt, input int pix);
		logic [31:0] w;
		quiesce();
		w = $urandom;
		w[0] = pal;
		write_reg(REG_PALETTE_ENABLE, w);
		w = $urandom;
		w[0] = dlt;
		write_reg(REG_DELTA_ENABLE, w);
		w = $urandom;
		w[COUNT_W-1:0] = COUNT_W'(pix);
		write_reg(REG_EXPECTED_PIXELS, w);
	endtask

	// Full palette load, low byte first. The first entry is black and the last one white so
	// that the lookup extremes are always present.
	task automatic load_palette();
		logic [15:0] w;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			w = 16'($urandom);
			if (i == 0)
				w = 16'h0000;
			else if (i == PALETTE_ENTRIES - 1)
				w = 16'hFFFF;
			put_byte(w[7:0], 1'b0);
			put_byte(w[15:8], 1'b0);
		end
	endtask

	task automatic put_word(input logic [15:0] w, input logic last);
		put_byte(w[7:0], 1'b0);
		put_byte(w[15:8], last);
	endtask

	task automatic put_escape(input logic [15:0] w, input logic last);
		put_byte(ESCAPE_CODE, 1'b0);
		put_word(w, last);
	endtask

	// One random image stream. Raw streams mostly end with the last flag on the final byte
	// of a pixel, some of those with a wrong expected count; the rest stop inside a pair.
	// Now and then the delta setting is rewritten in the middle with a random value.
	// Palette-mode streams stop inside the palette load.
	task automatic random_stream();
		bit          pal;
		bit          clean;
		bit          fin;
		int          kind;
		int          syms;
		int          n;
		int          want;
		logic [15:0] w;
		pal   = ($urandom_range(99) < 25);
		kind  = $urandom_range(99);
		clean = (kind < 80);
		syms  = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		want  = syms;
		if (kind >= 70 && kind < 80)
			want = $urandom_range(1) ? syms + 1 : $urandom_range(1, MAX_PIXELS);
		case ($urandom_range(2))
			0: gap_pct = 0;
			1: gap_pct = 8;
			default: gap_pct = 25;
		endcase
		if (calm)
			gap_pct = 0;
		set_mode(pal, 1'($urandom_range(1)), want);

		if (pal) begin
			// Stream that ends while the palette is still loading.
			n = $urandom_range(0, 24);
			repeat (n) put_byte(8'($urandom), 1'b0);
			put_byte(8'($urandom), 1'b1);
		end else begin
			for (int i = 0; i < syms; i++) begin
				fin = clean && (i == syms - 1);
				w = 16'($urandom);
				put_word(w, fin);
				if (i < syms - 1 && $urandom_range(24) == 0) begin
					quiesce();
					write_reg(REG_DELTA_ENABLE, $urandom);
				end
			end
			// Broken ending: the last byte leaves a pair unfinished.
			if (!clean)
				put_byte(8'($urandom), 1'b1);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		stream_ch.valid     = 1'b0;
		stream_ch.data_byte = 8'h00;
		stream_ch.last_byte = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_PALETTE_ENABLE;
		cfg_ch.data         = 32'h0;
		pixel_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed part. Registers are still at their reset values: palette mode, no delta,
		// one expected pixel. A stream that ends inside the palette load is truncated, and
		// so is a stream made of a single byte.
		put_byte(8'h00, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'h5A, 1'b1);
		put_byte(ESCAPE_CODE, 1'b1);

		// Raw pairs at both extremes with the count matching.
		set_mode(1'b0, 1'b0, 2);
		put_word(16'h0000, 1'b0);
		put_word(16'hFFFF, 1'b1);

		// Raw with delta: every channel wraps around on the second pixel. The stream then
		// stops on a lone low byte, so truncation wins over the count mismatch.
		set_mode(1'b0, 1'b1, MAX_PIXELS);
		put_word(16'hFFFF, 1'b0);
		put_word(16'h0821, 1'b0);
		put_word(16'hF81F, 1'b0);
		put_byte(8'h3C, 1'b1);
		// A complete stream whose count differs from the largest expected count.
		put_word(16'h1234, 1'b1);

		// Palette mode: lookups of the first, the last and a middle entry, an escape, and a
		// run of random codes and escapes, with idling on both sides.
		gap_pct = 25;
		set_mode(1'b1, 1'b0, 10 + RUN_SYMS);
		load_palette();
		put_byte(8'h00, 1'b0);
		put_byte(8'(PALETTE_ENTRIES - 1), 1'b0);
		put_byte(8'h80, 1'b0);
		put_escape(16'h1234, 1'b0);
		for (int i = 0; i < RUN_SYMS; i++) begin
			if ($urandom_range(3) == 0)
				put_escape(16'($urandom), 1'b0);
			else
				put_byte(8'($urandom_range(0, PALETTE_ENTRIES - 1)), 1'b0);
		end

		// Mode changes in the middle of the same stream: delta is turned on, an escape is
		// left half done, raw mode and no delta are selected, and the escape still completes.
		// After one raw pair palette mode comes back and codes are looked up without a new
		// load. The final code brings the count to the expected value.
		quiesce();
		write_reg(REG_DELTA_ENABLE, 32'h1);
		put_byte(8'(PALETTE_ENTRIES - 1), 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(ESCAPE_CODE, 1'b0);
		put_byte(8'h34, 1'b0);
		quiesce();
		write_reg(REG_PALETTE_ENABLE, 32'h0);
		write_reg(REG_DELTA_ENABLE, 32'h0);
		put_byte(8'h12, 1'b0);
		put_word(16'hABCD, 1'b0);
		quiesce();
		write_reg(REG_PALETTE_ENABLE, 32'h1);
		write_reg(REG_DELTA_ENABLE, 32'h1);
		put_byte(8'h03, 1'b0);
		put_byte(8'h01, 1'b1);
		gap_pct = 0;

		// A raw stream switched to palette mode partway: the palette is then not loaded at
		// the end, so the stream is truncated although the count matches.
		set_mode(1'b0, 1'b0, 1);
		put_word(16'h5555, 1'b0);
		quiesce();
		write_reg(REG_PALETTE_ENABLE, 32'h1);
		put_byte(8'h11, 1'b1);

		// Random part. The closing stretch runs without any idling on either side.
		while (content < ITEMS) begin
			if (content >= ITEMS - 60)
				calm = 1'b1;
			random_stream();
		end

		calm = 1'b1;
		quiesce();
		if (mismatches == 0 && waiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
